// ===== hdl/stack_of_stacks_engine_assert.svh =====
// assertion macros shared by the stack engine modules
// expects clk_i and rst_ni in the scope of every use
`ifndef STACK_OF_STACKS_ENGINE_ASSERT_SVH
`define STACK_OF_STACKS_ENGINE_ASSERT_SVH

// condition holds at every clock edge out of reset
`define SOS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define SOS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sos_pkg.sv =====
// shared types and codes of the stack-of-stacks engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sos_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_PEEK     = 3'd2,
    CMD_DUP      = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_SPLIT    = 3'd5,
    CMD_COLLAPSE = 3'd6,
    CMD_XFER     = 3'd7
  } cmd_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_NO_SOSS  = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] operand;
  } sos_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [4:0]         stack_count;
    logic [1:0]         status;
  } sos_out_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_SB, OP_PUSH, OP_RD_TOP, OP_POP, OP_PEEK, OP_CLEAR,
    OP_SET_FULL, OP_SET_NOSOSS, OP_CUT_INIT, OP_NEW_STACK, OP_PAD_INIT,
    OP_MV_RD, OP_MV_WR_DN, OP_MV_WR_UP, OP_PZ_INIT, OP_ZERO, OP_FILL_INIT,
    OP_MVUP_INIT, OP_SOSS_POP, OP_DROP, OP_XIN_INIT, OP_XIN_P2, OP_XOUT_INIT,
    OP_XOUT_P2, OP_SW_RA, OP_SW_RB, OP_SW_WA, OP_SW_WB, OP_XFER_FIN,
    OP_XFER_PAD, OP_REBASE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   res_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       neg;
    logic       mag_zero;
    logic       d_zero;
    logic       mag_le_d;
    logic       cnt_full;
    logic       cnt_lt2;
    logic       len_zero;
    logic       len_ge2;
    logic       mag_gt_k;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sos_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/sos_datapath.sv =====
// datapath: pointers, stack count, cell and base memories, result register
// depends on sos_pkg, sos_ram and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "stack_of_stacks_engine_assert.svh"

module sos_datapath import sos_pkg::*; #(
  parameter int CELL_DEPTH = 1024,
  parameter int MAX_STACKS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire sos_in_t  in_data_i,
  input  wire dp_ctrl_t ctrl_i,
  output dp_stat_t      stat_o,
  output sos_out_t      out_data_o
);

  localparam int AW = $clog2(CELL_DEPTH);
  localparam int PW = AW + 1;
  localparam int SW = $clog2(MAX_STACKS);
  localparam int CW = $clog2(MAX_STACKS + 1);

  logic [2:0]    cmd_q, cmd_d;
  logic [31:0]   opnd_q, opnd_d;
  logic [PW-1:0] tp_q, tp_d, b_q, b_d, sb_q, sb_d, nb_q, nb_d, k_q, k_d, pad_q, pad_d;
  logic [PW-1:0] ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d, len_q, len_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   tmp_q, tmp_d, read_q, read_d;
  logic [1:0]    status_q, status_d;
  sos_out_t      out_q, out_d;

  logic          neg;
  logic [31:0]   mag, want;
  logic [PW-1:0] d, sd, fr, k_in, k_out, lim, bnew;
  logic          cut;
  logic [SW-1:0] top_idx, sb_idx, new_idx;
  logic [31:0]   push_data;

  logic          cell_we, cell_re;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [31:0]   cell_wdata, cell_rd;
  logic          base_we, base_re;
  logic [SW-1:0] base_waddr, base_raddr;
  logic [PW-1:0] base_wdata, base_rd;

  sos_ram #(.WIDTH(32), .DEPTH(CELL_DEPTH)) u_cells (
    .clk_i     (clk_i),
    .wr_en_i   (cell_we),
    .wr_addr_i (cell_waddr),
    .wr_data_i (cell_wdata),
    .rd_en_i   (cell_re),
    .rd_addr_i (cell_raddr),
    .rd_data_o (cell_rd)
  );

  sos_ram #(.WIDTH(PW), .DEPTH(MAX_STACKS)) u_bases (
    .clk_i     (clk_i),
    .wr_en_i   (base_we),
    .wr_addr_i (base_waddr),
    .wr_data_i (base_wdata),
    .rd_en_i   (base_re),
    .rd_addr_i (base_raddr),
    .rd_data_o (base_rd)
  );

  assign neg     = opnd_q[31];
  assign mag     = neg ? (32'd0 - opnd_q) : opnd_q;
  assign d       = tp_q - b_q;
  assign sd      = b_q - sb_q;
  assign fr      = PW'(CELL_DEPTH) - tp_q;
  assign k_in    = (mag < 32'(sd)) ? mag[PW-1:0] : sd;
  assign k_out   = (mag < 32'(d)) ? mag[PW-1:0] : d;
  assign top_idx = SW'(cnt_q - CW'(1));
  assign sb_idx  = SW'(cnt_q - CW'(2));
  assign new_idx = SW'(cnt_q);
  assign bnew    = neg ? (b_q + k_q) : (b_q - k_q);

  // padding request depends on which step asks for it
  always_comb begin
    case (ctrl_i.op)
      OP_PAD_INIT:  want = mag - 32'(d);
      OP_FILL_INIT: want = mag;
      default:      want = mag - 32'(k_q);
    endcase
  end

  assign cut = want > 32'(fr);
  assign lim = cut ? fr : want[PW-1:0];

  assign push_data = (cmd_q == CMD_PUSH) ? opnd_q : ((d == '0) ? 32'd0 : cell_rd);

  always_comb begin
    cmd_d      = cmd_q;
    opnd_d     = opnd_q;
    tp_d       = tp_q;
    b_d        = b_q;
    sb_d       = sb_q;
    nb_d       = nb_q;
    k_d        = k_q;
    pad_d      = pad_q;
    ptr_a_d    = ptr_a_q;
    ptr_b_d    = ptr_b_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    tmp_d      = tmp_q;
    read_d     = read_q;
    status_d   = status_q;
    cell_we    = 1'b0;
    cell_waddr = ptr_b_q[AW-1:0];
    cell_wdata = cell_rd;
    cell_re    = 1'b0;
    cell_raddr = ptr_a_q[AW-1:0];
    base_we    = 1'b0;
    base_waddr = top_idx;
    base_wdata = nb_q;
    base_re    = 1'b0;
    base_raddr = sb_idx;

    unique case (ctrl_i.op)
      OP_NONE: ;
      OP_LOAD: begin
        cmd_d    = in_data_i.command;
        opnd_d   = in_data_i.operand;
        read_d   = 32'd0;
        status_d = ST_OK;
        base_re  = 1'b1;
      end
      // stack 0 always starts at cell 0
      OP_SB: sb_d = (cnt_q == CW'(2)) ? '0 : base_rd;
      OP_PUSH: begin
        if (tp_q < PW'(CELL_DEPTH)) begin
          cell_we    = 1'b1;
          cell_waddr = tp_q[AW-1:0];
          cell_wdata = push_data;
          tp_d       = tp_q + PW'(1);
        end else begin
          status_d = ST_OVERFLOW;
        end
      end
      OP_RD_TOP: begin
        cell_re    = 1'b1;
        cell_raddr = AW'(tp_q - PW'(1));
      end
      OP_POP: begin
        read_d = cell_rd;
        tp_d   = tp_q - PW'(1);
      end
      OP_PEEK:       read_d = cell_rd;
      OP_CLEAR:      tp_d = b_q;
      OP_SET_FULL:   status_d = ST_OVERFLOW;
      OP_SET_NOSOSS: status_d = ST_NO_SOSS;
      OP_CUT_INIT:   nb_d = tp_q - mag[PW-1:0];
      OP_NEW_STACK: begin
        base_we    = 1'b1;
        base_waddr = new_idx;
        base_wdata = nb_q;
        b_d        = nb_q;
        cnt_d      = cnt_q + CW'(1);
      end
      OP_PAD_INIT: begin
        pad_d   = lim;
        ptr_a_d = tp_q - PW'(1);
        ptr_b_d = tp_q - PW'(1) + lim;
        len_d   = d;
        nb_d    = b_q;
        if (cut) status_d = ST_OVERFLOW;
      end
      OP_MV_RD: cell_re = 1'b1;
      OP_MV_WR_DN: begin
        cell_we = 1'b1;
        ptr_a_d = ptr_a_q - PW'(1);
        ptr_b_d = ptr_b_q - PW'(1);
        len_d   = len_q - PW'(1);
      end
      OP_MV_WR_UP: begin
        cell_we = 1'b1;
        ptr_a_d = ptr_a_q + PW'(1);
        ptr_b_d = ptr_b_q + PW'(1);
        len_d   = len_q - PW'(1);
      end
      OP_PZ_INIT: begin
        ptr_b_d = b_q;
        len_d   = pad_q;
        tp_d    = tp_q + pad_q;
      end
      OP_ZERO: begin
        cell_we    = 1'b1;
        cell_wdata = 32'd0;
        ptr_b_d    = ptr_b_q + PW'(1);
        len_d      = len_q - PW'(1);
      end
      OP_FILL_INIT: begin
        ptr_b_d = tp_q;
        len_d   = lim;
        tp_d    = tp_q + lim;
        nb_d    = tp_q + lim;
        if (cut) status_d = ST_OVERFLOW;
      end
      OP_MVUP_INIT: begin
        ptr_a_d = tp_q - mag[PW-1:0];
        ptr_b_d = b_q;
        len_d   = mag[PW-1:0];
        tp_d    = b_q + mag[PW-1:0];
      end
      // base moves down with the pointer so it never sits above the top
      OP_SOSS_POP: begin
        tp_d = b_q - k_in;
        b_d  = sb_q;
      end
      OP_DROP: begin
        cnt_d = cnt_q - CW'(1);
        b_d   = sb_q;
      end
      // transfers rotate in place by two reversals
      OP_XIN_INIT: begin
        k_d     = k_in;
        ptr_a_d = b_q;
        ptr_b_d = tp_q - PW'(1);
        len_d   = d;
      end
      OP_XIN_P2: begin
        ptr_a_d = b_q - k_q;
        ptr_b_d = tp_q - PW'(1);
        len_d   = d + k_q;
      end
      OP_XOUT_INIT: begin
        k_d     = k_out;
        ptr_a_d = b_q;
        ptr_b_d = tp_q - k_out - PW'(1);
        len_d   = d - k_out;
      end
      OP_XOUT_P2: begin
        ptr_a_d = b_q;
        ptr_b_d = tp_q - PW'(1);
        len_d   = d;
      end
      OP_SW_RA: cell_re = 1'b1;
      OP_SW_RB: begin
        cell_re    = 1'b1;
        cell_raddr = ptr_b_q[AW-1:0];
        tmp_d      = cell_rd;
      end
      OP_SW_WA: begin
        cell_we    = 1'b1;
        cell_waddr = ptr_a_q[AW-1:0];
      end
      OP_SW_WB: begin
        cell_we    = 1'b1;
        cell_wdata = tmp_q;
        ptr_a_d    = ptr_a_q + PW'(1);
        ptr_b_d    = ptr_b_q - PW'(1);
        len_d      = len_q - PW'(2);
      end
      OP_XFER_FIN: begin
        b_d        = bnew;
        base_we    = 1'b1;
        base_wdata = bnew;
      end
      OP_XFER_PAD: begin
        ptr_b_d = tp_q;
        len_d   = lim;
        tp_d    = tp_q + lim;
        if (cut) status_d = ST_OVERFLOW;
      end
      OP_REBASE: begin
        b_d        = tp_q;
        base_we    = 1'b1;
        base_wdata = tp_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d = out_q;
    if (ctrl_i.res_load) begin
      out_d.read_value  = read_q;
      out_d.stack_count = 5'(cnt_q);
      out_d.status      = status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q  <= '0;
      b_q   <= '0;
      cnt_q <= CW'(1);
    end else begin
      tp_q  <= tp_d;
      b_q   <= b_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    opnd_q   <= opnd_d;
    sb_q     <= sb_d;
    nb_q     <= nb_d;
    k_q      <= k_d;
    pad_q    <= pad_d;
    ptr_a_q  <= ptr_a_d;
    ptr_b_q  <= ptr_b_d;
    len_q    <= len_d;
    tmp_q    <= tmp_d;
    read_q   <= read_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.neg      = neg;
  assign stat_o.mag_zero = (mag == 32'd0);
  assign stat_o.d_zero   = (d == '0);
  assign stat_o.mag_le_d = (mag <= 32'(d));
  assign stat_o.cnt_full = (cnt_q >= CW'(MAX_STACKS));
  assign stat_o.cnt_lt2  = (cnt_q < CW'(2));
  assign stat_o.len_zero = (len_q == '0);
  assign stat_o.len_ge2  = (len_q >= PW'(2));
  assign stat_o.mag_gt_k = (mag > 32'(k_q));

  assign out_data_o = out_q;

  `SOS_ASSERT_ALWAYS(a_cnt_range, cnt_q != '0 && cnt_q <= CW'(MAX_STACKS), "stack count out of range")
  `SOS_ASSERT_ALWAYS(a_tp_range, tp_q <= PW'(CELL_DEPTH), "top pointer beyond cell store")
  `SOS_ASSERT_ALWAYS(a_base_below_top, b_q <= tp_q, "top stack base above top pointer")

endmodule

`default_nettype wire

// ===== hdl/sos_controller.sv =====
// controller: sequences the datapath steps of each command and the result handshake
// depends on sos_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "stack_of_stacks_engine_assert.svh"

module sos_controller import sos_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_ctrl_t      ctrl_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SB, S_PUSH, S_RD_TOP, S_RD_CAP, S_CLEAR, S_FULL, S_NOSOSS,
    S_CUT, S_NEW_STACK, S_PAD_INIT, S_MVDN_RD, S_MVDN_WR, S_PZ_INIT, S_ZERO,
    S_FILL_INIT, S_MVUP_INIT, S_MVUP_RD, S_MVUP_WR, S_SOSS_POP, S_DROP,
    S_XIN_INIT, S_XOUT_INIT, S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB, S_XP2,
    S_XFIN, S_XPAD, S_REBASE, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   pass_q, pass_d;
  logic   out_valid_q, out_valid_d;
  logic   pos;

  assign pos = !stat_i.neg && !stat_i.mag_zero;

  always_comb begin
    state_d         = state_q;
    pass_d          = pass_q;
    ctrl_o.op       = OP_NONE;
    ctrl_o.res_load = 1'b0;
    out_valid_d     = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.op = OP_LOAD;
          state_d   = S_SB;
        end
      end
      S_SB: begin
        ctrl_o.op = OP_SB;
        unique case (stat_i.cmd) inside
          CMD_PUSH: state_d = S_PUSH;
          CMD_POP, CMD_PEEK: state_d = stat_i.d_zero ? S_DONE : S_RD_TOP;
          CMD_DUP: state_d = stat_i.d_zero ? S_PUSH : S_RD_TOP;
          CMD_CLEAR: state_d = S_CLEAR;
          CMD_SPLIT: begin
            if (stat_i.cnt_full) state_d = S_FULL;
            else if (pos) state_d = stat_i.mag_le_d ? S_CUT : S_PAD_INIT;
            else state_d = S_FILL_INIT;
          end
          CMD_COLLAPSE: begin
            if (stat_i.cnt_lt2) state_d = S_NOSOSS;
            else if (pos) state_d = stat_i.mag_le_d ? S_MVUP_INIT : S_PAD_INIT;
            else state_d = S_SOSS_POP;
          end
          default: begin
            if (stat_i.cnt_lt2) state_d = S_NOSOSS;
            else state_d = stat_i.neg ? S_XOUT_INIT : S_XIN_INIT;
          end
        endcase
      end
      S_PUSH: begin
        ctrl_o.op = OP_PUSH;
        state_d   = S_DONE;
      end
      S_RD_TOP: begin
        ctrl_o.op = OP_RD_TOP;
        state_d   = S_RD_CAP;
      end
      S_RD_CAP: begin
        if (stat_i.cmd == CMD_POP) begin
          ctrl_o.op = OP_POP;
          state_d   = S_DONE;
        end else if (stat_i.cmd == CMD_PEEK) begin
          ctrl_o.op = OP_PEEK;
          state_d   = S_DONE;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_CLEAR: begin
        ctrl_o.op = OP_CLEAR;
        state_d   = S_DONE;
      end
      S_FULL: begin
        ctrl_o.op = OP_SET_FULL;
        state_d   = S_DONE;
      end
      S_NOSOSS: begin
        ctrl_o.op = OP_SET_NOSOSS;
        state_d   = S_DONE;
      end
      S_CUT: begin
        ctrl_o.op = OP_CUT_INIT;
        state_d   = S_NEW_STACK;
      end
      S_NEW_STACK: begin
        ctrl_o.op = OP_NEW_STACK;
        state_d   = S_DONE;
      end
      S_PAD_INIT: begin
        ctrl_o.op = OP_PAD_INIT;
        state_d   = S_MVDN_RD;
      end
      // shift the stack up by the pad, highest cell first
      S_MVDN_RD: begin
        if (stat_i.len_zero) begin
          state_d = S_PZ_INIT;
        end else begin
          ctrl_o.op = OP_MV_RD;
          state_d   = S_MVDN_WR;
        end
      end
      S_MVDN_WR: begin
        ctrl_o.op = OP_MV_WR_DN;
        state_d   = S_MVDN_RD;
      end
      S_PZ_INIT: begin
        ctrl_o.op = OP_PZ_INIT;
        state_d   = S_ZERO;
      end
      S_ZERO: begin
        if (!stat_i.len_zero) begin
          ctrl_o.op = OP_ZERO;
        end else if (stat_i.cmd == CMD_SPLIT) begin
          state_d = S_NEW_STACK;
        end else if (stat_i.cmd == CMD_COLLAPSE) begin
          state_d = S_DROP;
        end else begin
          state_d = stat_i.neg ? S_REBASE : S_DONE;
        end
      end
      S_FILL_INIT: begin
        ctrl_o.op = OP_FILL_INIT;
        state_d   = S_ZERO;
      end
      S_MVUP_INIT: begin
        ctrl_o.op = OP_MVUP_INIT;
        state_d   = S_MVUP_RD;
      end
      S_MVUP_RD: begin
        if (stat_i.len_zero) begin
          state_d = S_DROP;
        end else begin
          ctrl_o.op = OP_MV_RD;
          state_d   = S_MVUP_WR;
        end
      end
      S_MVUP_WR: begin
        ctrl_o.op = OP_MV_WR_UP;
        state_d   = S_MVUP_RD;
      end
      S_SOSS_POP: begin
        ctrl_o.op = OP_SOSS_POP;
        state_d   = S_DROP;
      end
      S_DROP: begin
        ctrl_o.op = OP_DROP;
        state_d   = S_DONE;
      end
      S_XIN_INIT: begin
        ctrl_o.op = OP_XIN_INIT;
        pass_d    = 1'b0;
        state_d   = S_SW_RA;
      end
      S_XOUT_INIT: begin
        ctrl_o.op = OP_XOUT_INIT;
        pass_d    = 1'b0;
        state_d   = S_SW_RA;
      end
      // each swap of the range ends reads both cells, then writes both back
      S_SW_RA: begin
        if (!stat_i.len_ge2) begin
          state_d = pass_q ? S_XFIN : S_XP2;
        end else begin
          ctrl_o.op = OP_SW_RA;
          state_d   = S_SW_RB;
        end
      end
      S_SW_RB: begin
        ctrl_o.op = OP_SW_RB;
        state_d   = S_SW_WA;
      end
      S_SW_WA: begin
        ctrl_o.op = OP_SW_WA;
        state_d   = S_SW_WB;
      end
      S_SW_WB: begin
        ctrl_o.op = OP_SW_WB;
        state_d   = S_SW_RA;
      end
      S_XP2: begin
        ctrl_o.op = stat_i.neg ? OP_XOUT_P2 : OP_XIN_P2;
        pass_d    = 1'b1;
        state_d   = S_SW_RA;
      end
      S_XFIN: begin
        ctrl_o.op = OP_XFER_FIN;
        state_d   = stat_i.mag_gt_k ? S_XPAD : S_DONE;
      end
      S_XPAD: begin
        ctrl_o.op = OP_XFER_PAD;
        state_d   = S_ZERO;
      end
      S_REBASE: begin
        ctrl_o.op = OP_REBASE;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.res_load = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `SOS_ASSERT_NEXT(a_accept_starts, in_valid_i && state_q == S_IDLE, state_q == S_SB, "accepted transaction did not start")
  `SOS_ASSERT_NEXT(a_load_shows, ctrl_o.res_load, out_valid_q, "result load without valid")
  `SOS_ASSERT_NEXT(a_done_waits, state_q == S_DONE && out_valid_q && out_stall_i, state_q == S_DONE, "result overwritten while stalled")

endmodule

`default_nettype wire

// ===== hdl/stack_of_stacks_engine.sv =====
// stack_of_stacks_engine: one command in, one result out, one command at a time.
// pop, peek and duplicate read the top cell first, unless the stack is empty; block moves
// copy one cell at a time, zero padding clears one cell at a time and a transfer swaps
// cell pairs. the next command is taken once the result is in the output register.
// reset: one empty stack, top pointer zero; rams need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module stack_of_stacks_engine import sos_pkg::*; #(
  parameter int CELL_DEPTH = 1024,
  parameter int MAX_STACKS = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire sos_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output sos_out_t     out_data_o
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  sos_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  sos_datapath #(
    .CELL_DEPTH (CELL_DEPTH),
    .MAX_STACKS (MAX_STACKS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
